[hw/rtl/cpr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Clock page replacement - shared package
// Widths, defaults, result codes and the controller/datapath handshake types.
// ---------------------------------------------------------------------------
package cpr_pkg;

  localparam int DEF_MAX_FRAMES = 16;
  localparam int DEF_PAGE_BITS  = 16;

  localparam int CFG_W     = 5;
  localparam int FAULT_W   = 32;
  localparam int OUTCOME_W = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd4;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_FILL  = 2'd0,
    OUT_HIT   = 2'd1,
    OUT_FAULT = 2'd2
  } cpr_outcome_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming page
    logic resolve;  // lookup: hit, fill or start of a fault
    logic step;     // one clock hand step of the sweep
  } cpr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_sweep;  // miss with every active frame full
    logic victim;      // use bit under the hand is clear
  } cpr_sts_t;

  function automatic int idx_width(input int frames);
    return (frames > 1) ? $clog2(frames) : 1;
  endfunction

endpackage

[hw/rtl/cpr_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Clock page replacement - channel interfaces
// Page reference channel and result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface cpr_req_if #(
  parameter int PAGE_BITS = cpr_pkg::DEF_PAGE_BITS
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface cpr_rsp_if #(
  parameter int PAGE_BITS = cpr_pkg::DEF_PAGE_BITS,
  parameter int IDX_W     = cpr_pkg::idx_width(cpr_pkg::DEF_MAX_FRAMES)
);
  import cpr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [IDX_W-1:0]     frame_index;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [FAULT_W-1:0]   fault_total;

  modport source (output valid, output outcome, output frame_index, output evicted_page,
                  output fault_total, input ready);
  modport sink   (input valid, input outcome, input frame_index, input evicted_page,
                  input fault_total, output ready);
endinterface

[hw/rtl/cpr_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Clock page replacement - controller
// Sequences capture, lookup and the hand sweep; owns the result valid flag.
// ---------------------------------------------------------------------------
module cpr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output cpr_pkg::cpr_cmd_t cmd,
  input  cpr_pkg::cpr_sts_t sts
);
  import cpr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP
  } state_t;

  state_t state;
  logic   slot_free;
  logic   done;

  // output register may still hold the previous beat
  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.capture = req_valid && req_ready;
    cmd.resolve = (state == ST_LOOKUP) && slot_free;
    cmd.step    = (state == ST_SWEEP);
  end

  // result ready: hit or fill at lookup, or the victim found by the sweep
  assign done = (cmd.resolve && !sts.need_sweep) || (cmd.step && sts.victim);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (done) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.capture) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (cmd.resolve) begin
            if (sts.need_sweep) begin
              state <= ST_SWEEP;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_SWEEP: begin
          // slot was free at lookup and nothing has filled it since
          if (sts.victim) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/cpr_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Clock page replacement - datapath
// Frame table, use bits, clock hand, fault counter and result registers.
// ---------------------------------------------------------------------------
module cpr_datapath #(
  parameter int MAX_FRAMES = cpr_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = cpr_pkg::DEF_PAGE_BITS,
  parameter int IDX_W      = cpr_pkg::idx_width(cpr_pkg::DEF_MAX_FRAMES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cpr_pkg::CFG_W-1:0]   cfg_data,
  input  logic [PAGE_BITS-1:0]        req_page,
  input  cpr_pkg::cpr_cmd_t           cmd,
  output cpr_pkg::cpr_sts_t           sts,
  output logic [cpr_pkg::OUTCOME_W-1:0] res_outcome,
  output logic [IDX_W-1:0]            res_index,
  output logic [PAGE_BITS-1:0]        res_evicted,
  output logic [cpr_pkg::FAULT_W-1:0] res_fault
);
  import cpr_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int NW    = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  logic [CFG_W-1:0]     frame_count;
  logic [PAGE_BITS-1:0] page_reg;
  logic [PAGE_BITS-1:0] frame_page [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [MAX_FRAMES-1:0] use_bit;
  logic [CNT_W-1:0]     fill_count;
  logic [IDX_W-1:0]     hand;
  logic [FAULT_W-1:0]   fault_count;

  logic [NW-1:0]        n_wide;
  logic [CNT_W-1:0]     n_act;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic                 fill_ok;
  logic [IDX_W-1:0]     fill_idx;
  logic [IDX_W-1:0]     hand_wrap;
  logic [CNT_W-1:0]     hand_inc;
  logic [IDX_W-1:0]     hand_adv;
  logic                 sat;

  // active frame count, clamped to 1..MAX_FRAMES
  always_comb begin
    if (frame_count == '0) begin
      n_wide = NW'(1);
    end else if (NW'(frame_count) > NW'(MAX_FRAMES)) begin
      n_wide = NW'(MAX_FRAMES);
    end else begin
      n_wide = NW'(frame_count);
    end
  end
  assign n_act = n_wide[CNT_W-1:0];

  // parallel tag compare, lowest matching frame wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (frame_valid[i] && (CNT_W'(i) < n_act) && (frame_page[i] == page_reg)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign fill_ok   = (fill_count < n_act);
  assign fill_idx  = fill_count[IDX_W-1:0];
  assign hand_wrap = (CNT_W'(hand) >= n_act) ? '0 : hand;
  assign hand_inc  = CNT_W'(hand) + CNT_W'(1);
  assign hand_adv  = (hand_inc >= n_act) ? '0 : hand_inc[IDX_W-1:0];
  assign sat       = (fault_count == '1);

  always_comb begin
    sts            = '0;
    sts.need_sweep = !hit && !fill_ok;
    sts.victim     = !use_bit[hand];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= CFG_RESET;
      frame_valid <= '0;
      use_bit     <= '1;
      fill_count  <= '0;
      hand        <= '0;
      fault_count <= '0;
    end else begin
      if (cfg_we) begin
        frame_count <= cfg_data;
      end
      if (cmd.resolve) begin
        if (hit) begin
          use_bit[hit_idx] <= 1'b1;
        end else if (fill_ok) begin
          frame_valid[fill_idx] <= 1'b1;
          fill_count            <= fill_count + CNT_W'(1);
        end else begin
          if (!sat) begin
            fault_count <= fault_count + FAULT_W'(1);
          end
          hand <= hand_wrap;
        end
      end
      if (cmd.step) begin
        if (use_bit[hand]) begin
          use_bit[hand] <= 1'b0;   // second chance
        end else begin
          use_bit[hand]     <= 1'b1;
          frame_valid[hand] <= 1'b1;
        end
        hand <= hand_adv;
      end
    end
  end

  // payload: frame table and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_reg <= req_page;
    end
    if (cmd.resolve) begin
      res_fault   <= fault_count;
      res_evicted <= '0;
      if (hit) begin
        res_outcome <= OUT_HIT;
        res_index   <= hit_idx;
      end else if (fill_ok) begin
        frame_page[fill_idx] <= page_reg;
        res_outcome          <= OUT_FILL;
        res_index            <= fill_idx;
      end
    end
    if (cmd.step && !use_bit[hand]) begin
      frame_page[hand] <= page_reg;
      res_outcome      <= OUT_FAULT;
      res_index        <= hand;
      res_evicted      <= frame_page[hand];
      res_fault        <= fault_count;
    end
  end

endmodule

[hw/rtl/clock_page_replacement_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Clock page replacement unit - top level
// Second-chance page replacement over a small frame table.
// ---------------------------------------------------------------------------
// Usage:
//   req  : one page reference per beat (valid/ready).
//   rsp  : one result per reference: outcome, frame index, evicted page and
//          the running (saturating) fault count.
//   cfg  : cfg_we/cfg_data write the active frame count; write while idle.
// Result valid: a hit or a fill is resolved at lookup; a fault adds a sweep
//   of 1 to n+1 hand steps for n active frames, the sweep visiting one frame
//   per cycle.
// One reference in flight: a new beat is taken only once the controller is
//   back in idle after the last one's hit, fill or sweep.
// A finished result sits in the output register; the next reference is
//   accepted meanwhile and waits in lookup until the receiver takes the beat.
// Reset: frames empty, all use bits set, hand and fault count at zero,
//   frame count back to 4. No clearing pass is needed.
// ---------------------------------------------------------------------------
module clock_page_replacement_unit #(
  parameter int MAX_FRAMES = cpr_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = cpr_pkg::DEF_PAGE_BITS,
  parameter int IDX_W      = cpr_pkg::idx_width(MAX_FRAMES)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [cpr_pkg::CFG_W-1:0] cfg_data,
  cpr_req_if.sink                   req,
  cpr_rsp_if.source                 rsp
);
  import cpr_pkg::*;

  cpr_cmd_t cmd;
  cpr_sts_t sts;

  cpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cpr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .req_page    (req.page),
    .cmd         (cmd),
    .sts         (sts),
    .res_outcome (rsp.outcome),
    .res_index   (rsp.frame_index),
    .res_evicted (rsp.evicted_page),
    .res_fault   (rsp.fault_total)
  );

endmodule

[hw/rtl/cpr_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Clock page replacement - port checker
// Assertions on the top level's channels, bound to every instance.
// ---------------------------------------------------------------------------
module cpr_checker #(
  parameter int PAGE_BITS = cpr_pkg::DEF_PAGE_BITS,
  parameter int IDX_W     = cpr_pkg::idx_width(cpr_pkg::DEF_MAX_FRAMES)
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [cpr_pkg::OUTCOME_W-1:0] outcome,
  input logic [IDX_W-1:0]              frame_index,
  input logic [PAGE_BITS-1:0]          evicted_page,
  input logic [cpr_pkg::FAULT_W-1:0]   fault_total
);
  import cpr_pkg::*;

  // stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      rsp_valid && $stable(outcome) && $stable(frame_index) &&
      $stable(evicted_page) && $stable(fault_total))
    else $error("result beat changed while stalled");

  // one reference in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("reference accepted while another is in flight");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (outcome == OUT_FILL) || (outcome == OUT_HIT) || (outcome == OUT_FAULT))
    else $error("bad outcome code");

  // only a replacement reports an evicted page
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (outcome != OUT_FAULT) |-> (evicted_page == '0))
    else $error("evicted page on hit or fill");

endmodule

bind clock_page_replacement_unit cpr_checker #(
  .PAGE_BITS (PAGE_BITS),
  .IDX_W     (IDX_W)
) u_cpr_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .outcome      (rsp.outcome),
  .frame_index  (rsp.frame_index),
  .evicted_page (rsp.evicted_page),
  .fault_total  (rsp.fault_total)
);
